// ===== hdl/wss_pkg.sv =====
// shared types and constants of the wasm section scanner
`default_nettype none

package wss_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned WORD_W   = 32;
    localparam int unsigned GROUP_W  = 3;

    localparam logic [BYTE_W-1:0] LEB_DATA_MASK = 8'h7f;
    localparam logic [BYTE_W-1:0] LEB_CONT_MASK = 8'h80;

    // leb128 group counter: groups 0..4 carry bits, group 5 and up drop them
    localparam logic [GROUP_W-1:0] GROUP_SAT = 3'd5;

    typedef struct packed {
        logic [BYTE_W-1:0] module_byte;
        logic              first;
        logic              last;
    } in_item_t;

    typedef struct packed {
        logic              valid;
        in_item_t          item;
    } in_slot_t;

    typedef struct packed {
        logic              found;
        logic [WORD_W-1:0] content_offset;
        logic [WORD_W-1:0] content_size;
    } result_t;

endpackage

`default_nettype wire

// ===== hdl/wss_input_stage.sv =====
// input register in front of the scan core
`default_nettype none

module wss_input_stage
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [7:0]        s_tdata,
    input  wire logic              s_tuser,
    input  wire logic              s_tlast,
    input  wire logic              take,
    output wss_pkg::in_slot_t      slot
);
    import wss_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;
    logic     load;

    assign s_tready = !valid_reg || take;
    assign load     = s_tvalid && s_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.module_byte <= s_tdata;
            item_reg.first       <= s_tuser;
            item_reg.last        <= s_tlast;
        end
    end

    assign slot.valid = valid_reg;
    assign slot.item  = item_reg;

endmodule

`default_nettype wire

// ===== hdl/wss_scan_core.sv =====
// section walk state, leb128 decode and result register
`default_nettype none

module wss_scan_core
#(
    parameter int unsigned HEADER_BYTES = 8
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire wss_pkg::in_slot_t slot,
    output logic                   take,
    input  wire logic [7:0]        target_section,
    output logic                   res_valid,
    input  wire logic              res_ready,
    output wss_pkg::result_t       res
);
    import wss_pkg::*;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_ID,
        PH_SIZE,
        PH_SKIP,
        PH_DONE
    } phase_t;

    localparam logic [WORD_W-1:0] HDR_LEN = WORD_W'(HEADER_BYTES);

    phase_t               phase_reg, phase_next;
    logic [WORD_W-1:0]    pos_reg, pos_next;
    logic [WORD_W-1:0]    acc_reg, acc_next;
    logic [WORD_W-1:0]    skip_reg, skip_next;
    logic [BYTE_W-1:0]    id_reg, id_next;
    logic [GROUP_W-1:0]   grp_reg, grp_next;
    logic                 out_valid_reg, out_valid_next;
    result_t              out_reg, out_next;

    phase_t               ph_cur, ph_work;
    logic [WORD_W-1:0]    pos_cur, acc_cur, skip_cur, acc_or, part, low7;
    logic [BYTE_W-1:0]    id_cur, b;
    logic [GROUP_W-1:0]   grp_cur;
    logic                 emit;

    assign take = slot.valid && (!out_valid_reg || res_ready);
    assign b    = slot.item.module_byte;
    assign low7 = WORD_W'(b & LEB_DATA_MASK);

    always_comb
    begin
        unique case (grp_cur)
            3'd0:    part = low7;
            3'd1:    part = low7 << 7;
            3'd2:    part = low7 << 14;
            3'd3:    part = low7 << 21;
            3'd4:    part = low7 << 28;
            default: part = '0;
        endcase
    end

    always_comb
    begin
        // a first mark restarts the scan before the byte is looked at
        if (slot.item.first)
        begin
            ph_cur   = PH_HEADER;
            pos_cur  = '0;
            acc_cur  = '0;
            skip_cur = '0;
            id_cur   = '0;
            grp_cur  = '0;
        end
        else
        begin
            ph_cur   = phase_reg;
            pos_cur  = pos_reg;
            acc_cur  = acc_reg;
            skip_cur = skip_reg;
            id_cur   = id_reg;
            grp_cur  = grp_reg;
        end

        acc_or     = acc_cur | part;
        phase_next = ph_cur;
        pos_next   = pos_cur;
        acc_next   = acc_cur;
        skip_next  = skip_cur;
        id_next    = id_cur;
        grp_next   = grp_cur;
        emit       = 1'b0;
        out_next   = '0;
        ph_work    = ph_cur;

        if (ph_cur != PH_DONE)
        begin
            pos_next = pos_cur + 1'b1;
            if (ph_cur == PH_HEADER && pos_cur >= HDR_LEN)
            begin
                ph_work = PH_ID;
            end
            phase_next = ph_work;

            unique case (ph_work)
                PH_HEADER:
                begin
                end
                PH_ID:
                begin
                    id_next    = b;
                    acc_next   = '0;
                    grp_next   = '0;
                    phase_next = PH_SIZE;
                end
                PH_SIZE:
                begin
                    acc_next = acc_or;
                    if (grp_cur != GROUP_SAT)
                    begin
                        grp_next = grp_cur + 1'b1;
                    end
                    if ((b & LEB_CONT_MASK) == '0)
                    begin
                        if (id_cur == target_section)
                        begin
                            emit                    = 1'b1;
                            out_next.found          = 1'b1;
                            out_next.content_offset = pos_cur + 1'b1;
                            out_next.content_size   = acc_or;
                            phase_next              = PH_DONE;
                        end
                        else
                        begin
                            skip_next  = acc_or;
                            phase_next = (acc_or == '0) ? PH_ID : PH_SKIP;
                        end
                    end
                end
                PH_SKIP:
                begin
                    skip_next = skip_cur - 1'b1;
                    if (skip_next == '0)
                    begin
                        phase_next = PH_ID;
                    end
                end
                default:
                begin
                    phase_next = PH_DONE;
                end
            endcase

            // module ended before the target showed up
            if (!emit && slot.item.last)
            begin
                emit       = 1'b1;
                out_next   = '0;
                phase_next = PH_DONE;
            end
        end

        out_valid_next = out_valid_reg;
        if (take)
        begin
            out_valid_next = emit;
        end
        else if (res_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            pos_reg       <= '0;
            acc_reg       <= '0;
            skip_reg      <= '0;
            id_reg        <= '0;
            grp_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            if (take)
            begin
                phase_reg <= phase_next;
                pos_reg   <= pos_next;
                acc_reg   <= acc_next;
                skip_reg  <= skip_next;
                id_reg    <= id_next;
                grp_reg   <= grp_next;
            end
            if (take && emit)
            begin
                out_reg <= out_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

endmodule

`default_nettype wire

// ===== hdl/wasm_section_scanner.sv =====
// top level of the wasm section scanner
//
// channel   dir  tdata / data                        tuser   tlast
// s_*       in   [7:0] module_byte                   first   last
// m_*       out  [31:0] content_offset, [63:32] size found   -
// cfg_*     in   [7:0] target_section                -       -
//
// one byte per cycle sustained while no result stalls; a byte passes an
// input register and the scan logic, whose registered result raises
// m_tvalid; the result transfer takes place once m_tready is high
// rst_n clears the scan state and target_section to zero
// a stalled result holds the scan logic; s_tready stays high only while the
// input register is empty, so at most one more byte is taken
`default_nettype none

module wasm_section_scanner
#(
    parameter int unsigned HEADER_BYTES = 8
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // module_byte
    input  wire logic        s_tuser,   // first
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // content_offset, content_size
    output logic             m_tuser,   // found
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_data   // target_section
);
    import wss_pkg::*;

    in_slot_t          slot;
    logic              take;
    result_t           res;
    logic [BYTE_W-1:0] target_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            target_reg <= cfg_data;
        end
    end

    wss_input_stage u_input
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .take     (take),
        .slot     (slot)
    );

    wss_scan_core #(
        .HEADER_BYTES (HEADER_BYTES)
    ) u_core
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .slot           (slot),
        .take           (take),
        .target_section (target_reg),
        .res_valid      (m_tvalid),
        .res_ready      (m_tready),
        .res            (res)
    );

    assign m_tuser = res.found;
    assign m_tdata = {res.content_size, res.content_offset};

    // a not-found report carries zero offset and size
    a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("not-found result with nonzero payload");

    // a held byte in the input register is neither dropped nor changed
    a_slot_hold: assert property (@(posedge clk) disable iff (!rst_n)
        slot.valid && !take |=> slot.valid && $stable(slot.item))
        else $error("input register lost a byte");

    // a new result only follows a byte taken by the scan logic
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(take))
        else $error("result without a processed byte");

endmodule

`default_nettype wire

// ===== bench/wss_checker.sv =====
`timescale 1ns / 100ps
// result checker for the wasm section scanner: predicts every result and compares the output

module wss_checker
#(
    parameter int unsigned HEADER_BYTES = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tuser,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,
    input  logic        m_tuser,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    output int          error_count,
    output int          results_owed,
    output int          bytes_scanned,
    output int          results_seen
);
    import wss_pkg::*;

    localparam logic [5:0] SHIFT_KEEP = 6'd32;
    localparam logic [5:0] SHIFT_SAT  = 6'd35;
    localparam logic [5:0] SHIFT_STEP = 6'd7;

    typedef enum logic [2:0] {
        SCAN_HEADER,
        SCAN_ID,
        SCAN_SIZE,
        SCAN_SKIP,
        SCAN_DONE
    } scan_phase_e;

    scan_phase_e       phase;
    logic [WORD_W-1:0] position;
    logic [WORD_W-1:0] size_acc;
    logic [WORD_W-1:0] skip_left;
    logic [5:0]        size_shift;
    logic [BYTE_W-1:0] section_id;
    logic [BYTE_W-1:0] target;

    result_t owed_q[$];
    int      errs;
    int      scanned_n;
    int      seen_n;

    task automatic restart_scan();
        phase      = SCAN_HEADER;
        position   = '0;
        size_acc   = '0;
        size_shift = '0;
        section_id = '0;
        skip_left  = '0;
    endtask

    task automatic scan_byte(input in_item_t it, output bit has_result, output result_t r);
        logic [WORD_W-1:0] pos;
        has_result = 1'b0;
        r = '0;
        if (it.first)
            restart_scan();
        if (phase == SCAN_DONE)
            return;
        scanned_n++;
        pos = position;
        position = pos + 1;
        if (phase == SCAN_HEADER && pos >= HEADER_BYTES)
            phase = SCAN_ID;
        case (phase)
            SCAN_ID:
            begin
                section_id = it.module_byte;
                size_acc   = '0;
                size_shift = '0;
                phase      = SCAN_SIZE;
            end
            SCAN_SIZE:
            begin
                // groups past bit 31 are dropped, the shift count saturates
                if (size_shift < SHIFT_KEEP)
                    size_acc |= {24'd0, it.module_byte & LEB_DATA_MASK} << size_shift;
                if (size_shift < SHIFT_SAT)
                    size_shift += SHIFT_STEP;
                if ((it.module_byte & LEB_CONT_MASK) == '0)
                begin
                    if (section_id == target)
                    begin
                        has_result       = 1'b1;
                        r.found          = 1'b1;
                        r.content_offset = pos + 1;
                        r.content_size   = size_acc;
                        phase            = SCAN_DONE;
                        return;
                    end
                    skip_left = size_acc;
                    phase = (skip_left == '0) ? SCAN_ID : SCAN_SKIP;
                end
            end
            SCAN_SKIP:
            begin
                skip_left -= 1;
                if (skip_left == '0)
                    phase = SCAN_ID;
            end
            default:
            begin
            end
        endcase
        if (it.last)
        begin
            has_result = 1'b1;
            r          = '0;
            phase      = SCAN_DONE;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t  want;
        result_t  got;
        result_t  pred;
        in_item_t item;
        bit       hit;
        if (!rst_n)
        begin
            target = '0;
            restart_scan();
            owed_q.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.found          = m_tuser;
                got.content_offset = m_tdata[31:0];
                got.content_size   = m_tdata[63:32];
                seen_n++;
                if (owed_q.size() == 0)
                begin
                    errs++;
                    $display("%0t: unexpected result, expected none, %s %0d %0d %0d",
                             $time, "got found offset size",
                             got.found, got.content_offset, got.content_size);
                end
                else
                begin
                    want = owed_q.pop_front();
                    if (got.found !== want.found)
                    begin
                        errs++;
                        $display("%0t: found mismatch, expected %0d, got %0d",
                                 $time, want.found, got.found);
                    end
                    if (got.content_offset !== want.content_offset)
                    begin
                        errs++;
                        $display("%0t: content_offset mismatch, expected %0d, got %0d",
                                 $time, want.content_offset, got.content_offset);
                    end
                    if (got.content_size !== want.content_size)
                    begin
                        errs++;
                        $display("%0t: content_size mismatch, expected %0d, got %0d",
                                 $time, want.content_size, got.content_size);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                target = cfg_data;
            if (s_tvalid && s_tready)
            begin
                item.module_byte = s_tdata;
                item.first       = s_tuser;
                item.last        = s_tlast;
                scan_byte(item, hit, pred);
                if (hit)
                    owed_q.push_back(pred);
            end
        end
        error_count   <= errs;
        results_owed  <= owed_q.size();
        bytes_scanned <= scanned_n;
        results_seen  <= seen_n;
    end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// testbench top for the wasm section scanner: module image stimulus, idling and verdict

module tb;

    localparam int unsigned HEADER_BYTES = 8;
    localparam int          RANDOM_BYTES = 600;
    localparam int          PHASES       = 5;
    localparam int          SETTLE       = 8;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;    // module_byte
    logic        s_tuser   = 1'b0;  // first
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [63:0] m_tdata;           // content_offset, content_size
    logic        m_tuser;           // found
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data  = '0;    // target_section

    int send_idle = 0;
    int recv_idle = 0;
    int targets_n = 1;
    int sent_n    = 0;
    int err_n;
    int owed_n;
    int scanned_n;
    int seen_n;

    logic [7:0] image_q[$];

    wasm_section_scanner #(.HEADER_BYTES(HEADER_BYTES)) uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    wss_checker #(.HEADER_BYTES(HEADER_BYTES)) chk
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .error_count   (err_n),
        .results_owed  (owed_n),
        .bytes_scanned (scanned_n),
        .results_seen  (seen_n)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= recv_idle);

    initial
    begin
        #5_000_000;
        $display("tb: done, errors");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b, input logic is_first, input logic is_last);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= is_first;
        s_tlast  <= is_last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sent_n++;
    endtask

    // hold the sender until every predicted result has been taken
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (owed_n != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_target(input logic [7:0] t);
        cfg_valid <= 1'b1;
        cfg_data  <= t;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        targets_n++;
    endtask

    // leb128 of v, padded with continuation groups up to the given count
    task automatic push_leb(input logic [31:0] v, input int groups);
        int          n;
        int          i;
        logic [31:0] part;
        n = 1;
        while (n < 5 && (v >> (7 * n)) != 0)
            n++;
        if (groups > n)
            n = groups;
        for (i = 0; i < n; i++)
        begin
            part = v >> (7 * i);
            image_q.push_back({i < n - 1, part[6:0]});
        end
    endtask

    task automatic push_random_leb(input int groups);
        int          i;
        logic [31:0] part;
        for (i = 0; i < groups; i++)
        begin
            part = $urandom;
            image_q.push_back({i < groups - 1, part[6:0]});
        end
    endtask

    task automatic build_module(input logic [7:0] tgt);
        int         nsec;
        int         size;
        int         i;
        int         k;
        logic [7:0] id;
        image_q.delete();
        repeat (HEADER_BYTES) image_q.push_back(8'($urandom_range(255)));
        nsec = $urandom_range(4);
        for (i = 0; i < nsec; i++)
        begin
            k = $urandom_range(99);
            if (k < 25)
                id = tgt;
            else if (k < 35)
                id = $urandom_range(1) ? 8'h00 : 8'hff;
            else
                id = 8'($urandom_range(255));
            if (id == tgt && $urandom_range(2) == 0)
            begin
                push_random_leb($urandom_range(1, 7));
                repeat ($urandom_range(4)) image_q.push_back(8'($urandom_range(255)));
            end
            else
            begin
                size = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(5);
                push_leb(size, ($urandom_range(7) == 0) ? $urandom_range(2, 7) : 1);
                repeat (size) image_q.push_back(8'($urandom_range(255)));
            end
        end
        // trailing junk parses as a section that may run past the end
        if ($urandom_range(3) == 0)
            repeat ($urandom_range(1, 4)) image_q.push_back(8'($urandom_range(255)));
    endtask

    task automatic send_module();
        int n;
        int cut;
        int kind;
        int i;
        bit mark_first;
        bit mark_last;
        n = image_q.size();
        kind = $urandom_range(99);
        cut = n;
        mark_first = 1'b1;
        mark_last = 1'b1;
        if (kind >= 94)
            mark_first = 1'b0;
        else if (kind >= 86)
        begin
            cut = $urandom_range(1, n);
            mark_last = 1'b0;
        end
        else if (kind >= 70)
            cut = $urandom_range(1, n);
        for (i = 0; i < cut; i++)
            send_byte(image_q[i], mark_first && i == 0, mark_last && i == cut - 1);
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 12))
            send_byte(8'($urandom_range(255)), $urandom_range(7) == 0, $urandom_range(5) == 0);
    endtask

    initial
    begin
        int         ph;
        int         want_ph;
        int         mode;
        logic [7:0] tgt;
        logic [7:0] plan[PHASES];
        plan[0] = 8'hff;
        plan[1] = 8'($urandom_range(255));
        plan[2] = 8'h00;
        plan[3] = 8'($urandom_range(255));
        plan[4] = 8'h80;
        tgt = 8'h00;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_idle = 16;
        recv_idle = 73;

        // no first mark after reset, reset target 0, zero-length skip,
        // over-long size found on the module's last byte
        image_q = '{8'h00, 8'h61, 8'h73, 8'h6d, 8'h01, 8'h00, 8'h00, 8'h00,
                    8'hff, 8'h00,
                    8'h00, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'h01};
        foreach (image_q[i])
            send_byte(image_q[i], 1'b0, i == image_q.size() - 1);
        // ignored after the report
        send_byte(8'h5a, 1'b0, 1'b0);
        // module ends inside the header
        send_byte(8'hff, 1'b1, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'h7f, 1'b0, 1'b1);
        // one-byte module
        send_byte(8'h80, 1'b1, 1'b1);

        ph = -1;
        while (sent_n < RANDOM_BYTES)
        begin
            want_ph = sent_n * PHASES / RANDOM_BYTES;
            if (want_ph >= PHASES)
                want_ph = PHASES - 1;
            if (want_ph != ph)
            begin
                ph = want_ph;
                drain();
                tgt = plan[ph];
                write_target(tgt);
            end
            mode = sent_n * 3 / RANDOM_BYTES;
            if (mode == 0)
            begin
                send_idle = 16;
                recv_idle = 73;
            end
            else if (mode == 1)
            begin
                send_idle = 73;
                recv_idle = 16;
            end
            else
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            if ($urandom_range(9) == 0)
                drain();
            if ($urandom_range(99) < 8)
                send_noise();
            else
            begin
                build_module(tgt);
                send_module();
            end
        end

        drain();
        repeat (20) @(posedge clk);
        if (owed_n != 0)
            $display("%0t: %0d results never arrived", $time, owed_n);
        $display("tb: %0d bytes sent, %0d scanned, %0d results checked, %0d section targets",
                 sent_n, scanned_n, seen_n, targets_n);
        $display("tb: idling on either side, then none; one pause for all results per phase");
        if (err_n == 0 && owed_n == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/wss_pkg.sv
hdl/wss_input_stage.sv
hdl/wss_scan_core.sv
hdl/wasm_section_scanner.sv
bench/wss_checker.sv
bench/tb.sv
